### hdl/sfss_pkg.sv
package sfss_pkg;

    localparam int DEF_SCRIPT_LEN = 10;
    localparam int DEF_MAX_WALK   = 64;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // Item kinds carried on s_tuser
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Frame code that marks the end of the script
    localparam logic [7:0] CODE_END = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_RESP
    } seq_state_t;

    // Input item payload, last field in the lowest bits
    typedef struct packed {
        logic [15:0] entry_offset;
        logic [7:0]  entry_hold;
        logic [7:0]  entry_code;
        logic [3:0]  entry_slot;
    } in_item_t;

    // One script entry as stored in the table memory
    typedef struct packed {
        logic [15:0] offset;
        logic [7:0]  hold;
        logic [7:0]  code;
    } entry_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [15:0] x_offset;
        logic        playing;
        logic [6:0]  frame_number;
    } result_t;

endpackage

### hdl/sfss_ram.sv
module sfss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read of the entry being written returns the old data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sfss_seq.sv
module sfss_seq
    import sfss_pkg::*;
#(
    parameter int SCRIPT_LEN = DEF_SCRIPT_LEN,
    parameter int MAX_WALK   = DEF_MAX_WALK
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    mode,
    input  in_item_t                      item,
    output logic                          tbl_we,
    output logic [$clog2(SCRIPT_LEN)-1:0] tbl_waddr,
    output entry_t                        tbl_wdata,
    output logic [$clog2(SCRIPT_LEN)-1:0] rd_addr,
    input  entry_t                        tbl_rdata,
    output logic                          cnt_we,
    output logic [$clog2(SCRIPT_LEN)-1:0] cnt_waddr,
    output logic [7:0]                    cnt_wdata,
    input  logic [7:0]                    cnt_rdata,
    output logic                          res_valid,
    output result_t                       res,
    input  logic                          out_ready
);

    localparam int AW = $clog2(SCRIPT_LEN);
    localparam int IW = $clog2(SCRIPT_LEN + 1);
    localparam int WW = $clog2(MAX_WALK + 1);
    localparam logic [7:0]    LEN8       = 8'(SCRIPT_LEN);
    localparam logic [4:0]    SLOT_LIMIT = 5'(SCRIPT_LEN);
    localparam logic [IW-1:0] IDX_END    = IW'(SCRIPT_LEN);
    localparam logic [WW-1:0] WALK_LIMIT = WW'(MAX_WALK);

    seq_state_t state_reg, state_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [7:0]            hold_reg, hold_next;
    logic                  active_reg, active_next;
    logic [6:0]            frame_reg, frame_next;
    logic [15:0]           offset_reg, offset_next;
    logic [WW-1:0]         walked_reg, walked_next;
    logic [SCRIPT_LEN-1:0] cvalid_reg, cvalid_next;
    logic                  fwd_reg, fwd_next;
    logic [7:0]            fwd_cnt_reg, fwd_cnt_next;

    logic          accept;
    logic          slot_ok;
    logic [AW-1:0] idx_a;
    logic [7:0]    inc8;
    logic          inc_over;
    logic          tick_walk;
    logic          is_end;
    logic          is_loop;
    logic [7:0]    target8;
    logic [7:0]    cnt_cur;
    logic [7:0]    cnt_new;
    logic          pass;
    logic [7:0]    nxt8;
    logic          walk_over;
    logic          walk_limit;
    logic          walk_continue;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign slot_ok    = {1'b0, item.entry_slot} < SLOT_LIMIT;
    assign idx_a      = idx_reg[AW-1:0];
    assign inc8       = 8'(idx_reg) + 8'd1;
    assign inc_over   = inc8 >= LEN8;
    assign tick_walk  = (mode == MODE_TICK) && active_reg && (hold_reg == 8'd0) && !inc_over;

    assign is_end     = tbl_rdata.code == CODE_END;
    assign is_loop    = tbl_rdata.code[7] && !is_end;
    assign target8    = ~tbl_rdata.code - 8'd1;
    assign cnt_cur    = fwd_reg ? fwd_cnt_reg : (cvalid_reg[idx_a] ? cnt_rdata : 8'd0);
    assign cnt_new    = cnt_cur + 8'd1;
    assign pass       = (tbl_rdata.hold == cnt_new) || (tbl_rdata.hold == 8'd0);
    assign nxt8       = pass ? inc8 : target8;
    assign walk_over  = nxt8 >= LEN8;
    assign walk_limit = walked_reg >= WALK_LIMIT;
    assign walk_continue = is_loop && !walk_limit && !walk_over;

    assign res.frame_number = frame_reg;
    assign res.playing      = active_reg;
    assign res.x_offset     = offset_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (mode == MODE_START) begin
                        state_next = ST_START;
                    end else if (tick_walk) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_START: state_next = ST_RESP;
            ST_WALK: begin
                state_next = walk_continue ? ST_WALK : ST_RESP;
            end
            ST_RESP: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idx_next     = idx_reg;
        hold_next    = hold_reg;
        active_next  = active_reg;
        frame_next   = frame_reg;
        offset_next  = offset_reg;
        walked_next  = walked_reg;
        cvalid_next  = cvalid_reg;
        fwd_next     = 1'b0;
        fwd_cnt_next = fwd_cnt_reg;
        tbl_we       = 1'b0;
        tbl_waddr    = item.entry_slot[AW-1:0];
        tbl_wdata    = '{offset: item.entry_offset, hold: item.entry_hold,
                         code: item.entry_code};
        rd_addr      = '0;
        cnt_we       = 1'b0;
        cnt_waddr    = idx_a;
        cnt_wdata    = pass ? 8'd0 : cnt_new;
        res_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (mode)
                        MODE_LOAD: tbl_we = slot_ok;
                        MODE_START: rd_addr = '0;
                        MODE_TICK: begin
                            if (active_reg) begin
                                if (hold_reg != 8'd0) begin
                                    hold_next = hold_reg - 8'd1;
                                end else if (inc_over) begin
                                    // ran off the table: end of script
                                    idx_next    = IDX_END;
                                    frame_next  = 7'd0;
                                    active_next = 1'b0;
                                    offset_next = 16'd0;
                                end else begin
                                    idx_next    = inc8[IW-1:0];
                                    rd_addr     = inc8[AW-1:0];
                                    walked_next = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_START: begin
                idx_next    = '0;
                cvalid_next = '0;
                if (tbl_rdata.code == CODE_END) begin
                    frame_next = 7'd0;
                end else begin
                    active_next = 1'b1;
                    frame_next  = tbl_rdata.code[6:0];
                    hold_next   = tbl_rdata.hold;
                    offset_next = tbl_rdata.offset;
                end
            end
            ST_WALK: begin
                if (!is_loop) begin
                    if (is_end) begin
                        frame_next  = 7'd0;
                        active_next = 1'b0;
                        offset_next = 16'd0;
                    end else begin
                        frame_next  = tbl_rdata.code[6:0];
                        hold_next   = tbl_rdata.hold;
                        offset_next = tbl_rdata.offset;
                    end
                end else if (walk_limit) begin
                    frame_next  = 7'd0;
                    active_next = 1'b0;
                    offset_next = 16'd0;
                end else begin
                    walked_next        = walked_reg + WW'(1);
                    cnt_we             = 1'b1;
                    cvalid_next[idx_a] = 1'b1;
                    if (walk_over) begin
                        idx_next    = IDX_END;
                        frame_next  = 7'd0;
                        active_next = 1'b0;
                        offset_next = 16'd0;
                    end else begin
                        idx_next     = nxt8[IW-1:0];
                        rd_addr      = nxt8[AW-1:0];
                        // counter memory returns old data when the jump lands here
                        fwd_next     = (nxt8[AW-1:0] == idx_a);
                        fwd_cnt_next = cnt_wdata;
                    end
                end
            end
            ST_RESP: res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            hold_reg    <= 8'd0;
            active_reg  <= 1'b0;
            frame_reg   <= 7'd0;
            offset_reg  <= 16'd0;
            walked_reg  <= '0;
            cvalid_reg  <= '0;
            fwd_reg     <= 1'b0;
            fwd_cnt_reg <= 8'd0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            hold_reg    <= hold_next;
            active_reg  <= active_next;
            frame_reg   <= frame_next;
            offset_reg  <= offset_next;
            walked_reg  <= walked_next;
            cvalid_reg  <= cvalid_next;
            fwd_reg     <= fwd_next;
            fwd_cnt_reg <= fwd_cnt_next;
        end
    end

endmodule

### hdl/sfss_out.sv
module sfss_out
    import sfss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_valid,
    input  result_t              res,
    output logic                 out_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 load;

    assign out_ready = !m_tvalid_reg || m_tready;
    assign load      = res_valid && out_ready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'(res);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hdl/sprite_frame_script_sequencer_core.sv
// Sprite animation script player with loop entries.
// Input channel s_*: one transfer per item. s_tuser carries the item kind
// (load entry, start, tick); s_tdata carries slot, code, hold and offset.
// Result channel m_*: exactly one transfer per input item, in order, with
// the frame shown, the playing flag and the x offset.
// An item passes the sequencer's response state and then the output
// register before m_tvalid rises. A start first reads entry 0 in the start
// state. A tick that advances walks the script in the walk state, which
// reads the table and repeat counter memories once per visited entry; a
// walk stops after MAX_WALK loop entries. Load entries, unused kinds,
// stopped ticks and ticks that only count their hold down go straight to
// the response state. Flow: one item in flight at a time. s_tready rises
// again as soon as the result is placed in the output register, so the
// next item can be taken while that result still waits on a stalled
// m_tready; a second finished result then holds the sequencer until the
// output register empties.
// Reset: the player stops with frame 0, offset 0 and all repeat counters
// cleared; script entries hold no defined value until loaded.
module sprite_frame_script_sequencer_core
    import sfss_pkg::*;
#(
    parameter int SCRIPT_LEN = DEF_SCRIPT_LEN,
    parameter int MAX_WALK   = DEF_MAX_WALK
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [3:0] entry_slot, [11:4] entry_code, [19:12] entry_hold,
    // [35:20] entry_offset, [39:36] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] mode
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [6:0] frame_number, [7] playing, [23:8] x_offset
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(SCRIPT_LEN);

    in_item_t      item;
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    entry_t        tbl_wdata;
    logic [AW-1:0] rd_addr;
    entry_t        tbl_rdata;
    logic          cnt_we;
    logic [AW-1:0] cnt_waddr;
    logic [7:0]    cnt_wdata;
    logic [7:0]    cnt_rdata;
    logic          res_valid;
    result_t       res;
    logic          out_ready;

    // Unpack the payload; the top pad bits of s_tdata are dropped
    assign item = s_tdata[$bits(in_item_t)-1:0];

    // Script entries: code, hold and offset per slot
    sfss_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SCRIPT_LEN)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (rd_addr),
        .rdata (tbl_rdata)
    );

    // Repeat counters of loop entries, read alongside the table
    sfss_ram #(
        .WIDTH (8),
        .DEPTH (SCRIPT_LEN)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (rd_addr),
        .rdata (cnt_rdata)
    );

    // Sequencer: decode the item, walk the script, update player state
    sfss_seq #(
        .SCRIPT_LEN (SCRIPT_LEN),
        .MAX_WALK   (MAX_WALK)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .mode      (s_tuser),
        .item      (item),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .rd_addr   (rd_addr),
        .tbl_rdata (tbl_rdata),
        .cnt_we    (cnt_we),
        .cnt_waddr (cnt_waddr),
        .cnt_wdata (cnt_wdata),
        .cnt_rdata (cnt_rdata),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready)
    );

    // Output register: hold the result until the receiver takes it
    sfss_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
